@@ sv/lts_pkg.sv @@
// Shared types and constants for the time point store.
`default_nettype none
package lts_pkg;

  localparam int CAPACITY_DEF = 64;

  // Transaction codes on the input channel
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_POS_AT_T = 2'd1;
  localparam logic [1:0] OP_T_AT_POS = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ORIGIN_TIME     = 1'b0;
  localparam logic CFG_ORIGIN_POSITION = 1'b1;

  // Datapath step, one per controller state that touches data
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_DISPATCH,
    DP_APPEND,
    DP_SCAN_READ,
    DP_SCAN_SHIFT,
    DP_MUL_X_GO,
    DP_MUL_X_SAVE,
    DP_MUL_Y_GO,
    DP_MUL_Y_SAVE,
    DP_AREA,
    DP_AREA_CMP,
    DP_SHIFT_INIT,
    DP_SHIFT_READ,
    DP_SHIFT_WRITE,
    DP_INS_LAST,
    DP_Q_READ0,
    DP_Q_START,
    DP_Q_CLAMP,
    DP_BR_READ,
    DP_BR_CHECK,
    DP_IP_PREP,
    DP_IP_MUL_GO,
    DP_DIV_GO,
    DP_DIV_SAVE,
    DP_APPLY,
    DP_FINISH
  } dp_step_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_APPEND,
    S_SC_RD,
    S_SC_LD,
    S_MX_GO,
    S_MX_WT,
    S_MY_GO,
    S_MY_WT,
    S_AREA,
    S_CMP,
    S_SH_INIT,
    S_SH_RD,
    S_SH_WR,
    S_LAST,
    S_Q_RD0,
    S_Q_ST,
    S_Q_CLAMP,
    S_BR_RD,
    S_BR_CHK,
    S_IP_PREP,
    S_IM_GO,
    S_IM_WT,
    S_ID_GO,
    S_ID_WT,
    S_APPLY,
    S_FINISH
  } lts_state_t;

  typedef struct packed {
    dp_step_t step;
  } lts_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       full;
    logic       mul_done;
    logic       div_done;
    logic       scan_loaded;
    logic       scan_more;
    logic       shift_more;
    logic       clamp_hit;
    logic       br_end;
    logic       br_hit;
    logic       ip_done;
    logic       ip_mid;
    logic       out_free;
  } lts_status_t;

endpackage
`default_nettype wire

@@ sv/lts_ram.sv @@
// Generic single write, single read RAM with registered read data.
`default_nettype none
module lts_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/lts_mul.sv @@
// 64x64 multiplier built from four registered 32x32 partial products.
`default_nettype none
module lts_mul (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output logic [127:0]      product
);
  logic [63:0] a_r, b_r;
  logic [2:0]  cnt;
  logic        busy;
  logic [63:0] pp;
  logic [1:0]  pp_sh;
  logic [31:0] op_a, op_b;
  logic [1:0]  sh_sel;
  logic [127:0] pp_aligned;

  // partial product selection
  always_comb begin
    case (cnt[1:0])
      2'd0: begin op_a = a_r[31:0];  op_b = b_r[31:0];  sh_sel = 2'd0; end
      2'd1: begin op_a = a_r[31:0];  op_b = b_r[63:32]; sh_sel = 2'd1; end
      2'd2: begin op_a = a_r[63:32]; op_b = b_r[31:0];  sh_sel = 2'd1; end
      default: begin op_a = a_r[63:32]; op_b = b_r[63:32]; sh_sel = 2'd2; end
    endcase
  end

  always_comb begin
    case (pp_sh)
      2'd0:    pp_aligned = {64'd0, pp};
      2'd1:    pp_aligned = {32'd0, pp, 32'd0};
      default: pp_aligned = {pp, 64'd0};
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= a;
      b_r     <= b;
      product <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp    <= 64'(op_a * op_b);
        pp_sh <= sh_sel;
      end
      if (cnt != 3'd0) begin
        product <= product + pp_aligned;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/lts_div.sv @@
// Restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
`default_nettype none
module lts_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] hi,
  input  wire logic [63:0] lo,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] rem, lo_sh, d_r;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic        take;

  // trial subtraction
  assign trial = {rem, lo_sh[63]};
  assign take  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= hi;
      lo_sh    <= lo;
      d_r      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? 64'(trial - {1'b0, d_r}) : trial[63:0];
      lo_sh    <= {lo_sh[62:0], 1'b0};
      quotient <= {quotient[62:0], take};
    end
  end
endmodule
`default_nettype wire

@@ sv/lts_ctrl.sv @@
// Controller state machine sequencing insert, thinning and query steps.
`default_nettype none
module lts_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lts_pkg::lts_status_t status,
  output lts_pkg::lts_cmd_t        cmd
);
  import lts_pkg::*;

  lts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and step
  always_comb begin
    state_next = state;
    cmd.step   = DP_NOP;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step   = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.step = DP_DISPATCH;
        case (status.opcode)
          OP_INSERT:   state_next = status.full ? S_SC_RD : S_APPEND;
          OP_POS_AT_T: state_next = S_Q_RD0;
          OP_T_AT_POS: state_next = S_Q_RD0;
          default:     state_next = S_FINISH;
        endcase
      end
      S_APPEND: begin
        cmd.step   = DP_APPEND;
        state_next = S_FINISH;
      end
      S_SC_RD: begin
        cmd.step   = DP_SCAN_READ;
        state_next = S_SC_LD;
      end
      S_SC_LD: begin
        cmd.step   = DP_SCAN_SHIFT;
        state_next = status.scan_loaded ? S_MX_GO : S_SC_RD;
      end
      S_MX_GO: begin
        cmd.step   = DP_MUL_X_GO;
        state_next = S_MX_WT;
      end
      S_MX_WT: begin
        if (status.mul_done) begin
          cmd.step   = DP_MUL_X_SAVE;
          state_next = S_MY_GO;
        end
      end
      S_MY_GO: begin
        cmd.step   = DP_MUL_Y_GO;
        state_next = S_MY_WT;
      end
      S_MY_WT: begin
        if (status.mul_done) begin
          cmd.step   = DP_MUL_Y_SAVE;
          state_next = S_AREA;
        end
      end
      S_AREA: begin
        cmd.step   = DP_AREA;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.step   = DP_AREA_CMP;
        state_next = status.scan_more ? S_SC_RD : S_SH_INIT;
      end
      S_SH_INIT: begin
        cmd.step   = DP_SHIFT_INIT;
        state_next = S_SH_RD;
      end
      S_SH_RD: begin
        cmd.step   = DP_SHIFT_READ;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.step   = DP_SHIFT_WRITE;
        state_next = status.shift_more ? S_SH_RD : S_LAST;
      end
      S_LAST: begin
        cmd.step   = DP_INS_LAST;
        state_next = S_FINISH;
      end
      S_Q_RD0: begin
        cmd.step   = DP_Q_READ0;
        state_next = S_Q_ST;
      end
      S_Q_ST: begin
        cmd.step   = DP_Q_START;
        state_next = S_Q_CLAMP;
      end
      S_Q_CLAMP: begin
        cmd.step   = DP_Q_CLAMP;
        state_next = status.clamp_hit ? S_FINISH : S_BR_RD;
      end
      S_BR_RD: begin
        cmd.step   = DP_BR_READ;
        state_next = status.br_end ? S_IP_PREP : S_BR_CHK;
      end
      S_BR_CHK: begin
        cmd.step   = DP_BR_CHECK;
        state_next = status.br_hit ? S_IP_PREP : S_BR_RD;
      end
      S_IP_PREP: begin
        cmd.step = DP_IP_PREP;
        if (status.ip_done) begin
          state_next = S_FINISH;
        end else if (status.ip_mid) begin
          state_next = S_APPLY;
        end else begin
          state_next = S_IM_GO;
        end
      end
      S_IM_GO: begin
        cmd.step   = DP_IP_MUL_GO;
        state_next = S_IM_WT;
      end
      S_IM_WT: begin
        if (status.mul_done) begin
          state_next = S_ID_GO;
        end
      end
      S_ID_GO: begin
        cmd.step   = DP_DIV_GO;
        state_next = S_ID_WT;
      end
      S_ID_WT: begin
        if (status.div_done) begin
          cmd.step   = DP_DIV_SAVE;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.step   = DP_APPLY;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.step   = DP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

@@ sv/lts_dp.sv @@
// Datapath: point table, area scan, bracketing, interpolation and result register.
`default_nettype none
module lts_dp #(
  parameter int CAP = lts_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lts_pkg::lts_cmd_t    cmd,
  output lts_pkg::lts_status_t      status,
  input  wire logic [1:0]           opcode,
  input  wire logic signed [63:0]   point_time,
  input  wire logic [63:0]          point_position,
  input  wire logic signed [63:0]   now_time,
  input  wire logic [63:0]          now_position,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [63:0]               estimate,
  output logic                      dropped,
  output logic [5:0]                drop_slot
);
  import lts_pkg::*;

  localparam int IDXW = $clog2(CAP);
  localparam int CNTW = $clog2(CAP + 1);
  localparam logic [CNTW-1:0] CAP_C  = CNTW'(CAP);
  localparam logic [CNTW-1:0] LAST_C = CNTW'(CAP - 1);
  localparam logic [CNTW-1:0] TWO_C  = CNTW'(2);
  localparam logic [CNTW-1:0] THREE_C = CNTW'(3);

  // latched transaction and configuration
  logic [1:0]  op;
  logic [63:0] pt, pp, nt, np;
  logic [63:0] org_t, org_p;
  logic [CNTW-1:0] fill, ridx, best;

  // area scan window and products
  logic [63:0]  w0t, w0p, w1t, w1p, w2t, w2p;
  logic [127:0] x, y;
  logic [128:0] area, best_area;

  // query registers
  logic [63:0] st, sp, et, ep, prev_t, prev_p;
  logic [63:0] mag, n_r, d_r, q;
  logic        neg, sat;

  // staged and output results
  logic [63:0] res_est;
  logic        res_drop;
  logic [CNTW-1:0] res_slot;

  // memory
  logic             ram_we;
  logic [IDXW-1:0]  ram_waddr;
  logic [127:0]     ram_wdata, ram_rdata;
  logic [63:0]      rd_t, rd_p;

  assign rd_t = ram_rdata[127:64];
  assign rd_p = ram_rdata[63:0];

  lts_ram #(.WIDTH(128), .DEPTH(CAP)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ridx[IDXW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[IDXW-1:0];
    ram_wdata = {pt, pp};
    case (cmd.step)
      DP_APPEND: ram_we = 1'b1;
      DP_SHIFT_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = IDXW'(ridx - CNTW'(1));
        ram_wdata = ram_rdata;
      end
      DP_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = IDXW'(CAP - 1);
      end
      default: ram_we = 1'b0;
    endcase
  end

  // triangle side differences
  logic        na, nb, nc, nd;
  logic [63:0] a_abs, b_abs, c_abs, d_abs;
  assign na    = $signed(w1t) < $signed(w0t);
  assign a_abs = na ? w0t - w1t : w1t - w0t;
  assign nb    = w1p < w0p;
  assign b_abs = nb ? w0p - w1p : w1p - w0p;
  assign nc    = $signed(w2t) < $signed(w0t);
  assign c_abs = nc ? w0t - w2t : w2t - w0t;
  assign nd    = w2p < w0p;
  assign d_abs = nd ? w0p - w2p : w2p - w0p;

  // doubled area magnitude
  logic [128:0] area_sum, area_new;
  logic [127:0] area_dif;
  assign area_sum = {1'b0, x} + {1'b0, y};
  assign area_dif = (x >= y) ? x - y : y - x;
  assign area_new = ((nb ^ nc) != (na ^ nd)) ? area_sum : {1'b0, area_dif};

  // multiplier and divider
  logic         mul_start, mul_done, div_done;
  logic [63:0]  mul_a, mul_b, div_q;
  logic [127:0] prod;

  always_comb begin
    mul_start = 1'b1;
    mul_a     = n_r;
    mul_b     = mag;
    case (cmd.step)
      DP_MUL_X_GO: begin mul_a = b_abs; mul_b = c_abs; end
      DP_MUL_Y_GO: begin mul_a = a_abs; mul_b = d_abs; end
      DP_IP_MUL_GO: mul_start = 1'b1;
      default: mul_start = 1'b0;
    endcase
  end

  lts_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  lts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.step == DP_DIV_GO),
    .hi       (prod[127:64]),
    .lo       (prod[63:0]),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // query decisions
  logic by_time, clamp_hit, clamp_lo, below, start_e0;
  logic ip_done, ip_mid;
  logic [63:0] clamp_val;
  assign by_time  = (op == OP_POS_AT_T);
  assign start_e0 = (fill != '0) && ($signed(rd_t) < $signed(org_t));
  assign clamp_lo = by_time ? ($signed(pt) < $signed(st)) : (pp < sp);
  assign clamp_hit = clamp_lo ||
                     (by_time ? !($signed(pt) < $signed(et)) : (pp >= ep));
  assign clamp_val = clamp_lo ? (by_time ? sp : st) : (by_time ? ep : et);
  assign below    = by_time ? ($signed(rd_t) < $signed(pt)) : (rd_p < pp);
  assign ip_done  = by_time ? (ep == sp) : (et == st);
  assign ip_mid   = by_time ? (et == st) : (ep == sp);

  logic [63:0] base, applied;
  assign base    = by_time ? sp : st;
  assign applied = neg ? base - q : base + q;

  // status to the controller
  always_comb begin
    status.opcode      = op;
    status.full        = (fill == CAP_C);
    status.mul_done    = mul_done;
    status.div_done    = div_done;
    status.scan_loaded = (ridx >= TWO_C);
    status.scan_more   = (ridx < CAP_C);
    status.shift_more  = (ridx < LAST_C);
    status.clamp_hit   = clamp_hit;
    status.br_end      = (ridx >= fill);
    status.br_hit      = !below;
    status.ip_done     = ip_done;
    status.ip_mid      = ip_mid;
    status.out_free    = !out_valid || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
      org_t     <= '0;
      org_p     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ORIGIN_TIME) begin
          org_t <= cfg_data;
        end else begin
          org_p <= cfg_data;
        end
      end
      if (cmd.step == DP_APPEND) begin
        fill <= fill + CNTW'(1);
      end
      if (cmd.step == DP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.step)
      DP_LOAD: begin
        op       <= opcode;
        pt       <= point_time;
        pp       <= point_position;
        nt       <= now_time;
        np       <= now_position;
        res_est  <= '0;
        res_drop <= 1'b0;
        res_slot <= '0;
      end
      DP_DISPATCH: ridx <= '0;
      DP_SCAN_SHIFT: begin
        w0t  <= w1t; w0p <= w1p;
        w1t  <= w2t; w1p <= w2p;
        w2t  <= rd_t; w2p <= rd_p;
        ridx <= ridx + CNTW'(1);
      end
      DP_MUL_X_SAVE: x <= prod;
      DP_MUL_Y_SAVE: y <= prod;
      DP_AREA: area <= area_new;
      DP_AREA_CMP: begin
        if (ridx == THREE_C || area < best_area) begin
          best_area <= area;
          best      <= ridx - TWO_C;
        end
      end
      DP_SHIFT_INIT: ridx <= best + CNTW'(1);
      DP_SHIFT_WRITE: ridx <= ridx + CNTW'(1);
      DP_INS_LAST: begin
        res_drop <= 1'b1;
        res_slot <= best;
      end
      DP_Q_START: begin
        st <= start_e0 ? rd_t : org_t;
        sp <= start_e0 ? rd_p : org_p;
        et <= nt;
        ep <= np;
      end
      DP_Q_CLAMP: begin
        if (clamp_hit) begin
          res_est <= clamp_val;
        end
        ridx <= '0;
      end
      DP_BR_READ: begin
        if ((ridx >= fill) && (fill != '0)) begin
          st <= prev_t;
          sp <= prev_p;
        end
      end
      DP_BR_CHECK: begin
        if (below) begin
          prev_t <= rd_t;
          prev_p <= rd_p;
          ridx   <= ridx + CNTW'(1);
        end else begin
          et <= rd_t;
          ep <= rd_p;
          if (ridx != '0) begin
            st <= prev_t;
            sp <= prev_p;
          end
        end
      end
      DP_IP_PREP: begin
        if (by_time) begin
          neg <= ep < sp;
          mag <= (ep < sp) ? sp - ep : ep - sp;
          q   <= ((ep < sp) ? sp - ep : ep - sp) >> 1;
          n_r <= pt - st;
          d_r <= et - st;
          sat <= 1'b0;
          if (ip_done) res_est <= ep;
        end else begin
          neg <= $signed(et) < $signed(st);
          mag <= ($signed(et) < $signed(st)) ? st - et : et - st;
          q   <= (($signed(et) < $signed(st)) ? st - et : et - st) >> 1;
          n_r <= pp - sp;
          d_r <= ep - sp;
          sat <= !ip_mid;
          if (ip_done) res_est <= et;
        end
      end
      DP_DIV_SAVE: q <= div_q;
      DP_APPLY: res_est <= (sat && applied[63]) ? '0 : applied;
      DP_FINISH: begin
        estimate  <= res_est;
        dropped   <= res_drop;
        drop_slot <= 6'(res_slot);
      end
      default: ;
    endcase
  end

  // checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= CAP_C)
    else $error("fill count beyond capacity");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == DP_FINISH) |-> (!out_valid || out_ready))
    else $error("result written over a pending transaction");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == DP_DIV_GO) |-> (d_r != '0))
    else $error("interpolation divisor is zero");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == DP_INS_LAST) |-> (fill == CAP_C))
    else $error("eviction while table not full");
endmodule
`default_nettype wire

@@ sv/lsn_time_point_store.sv @@
// Top level of the time point store: controller plus datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  in       | in_valid / in_ready        | opcode, point_time, point_position,
//           |                            | now_time, now_position
//  out      | out_valid / out_ready      | estimate, dropped, drop_slot
//  cfg      | cfg_we (no wait)           | cfg_index, cfg_data
//
// One transaction at a time. Append insert writes the point at the fill index. Full
// insert fills the first window, then scans CAPACITY-2 interior triples with two
// multiplies each on the shared multiplier, and then moves each entry above the
// evicted one down a slot before the new point is written into the last slot.
// Queries scan stored entries to bracket the point, and where needed the multiplier
// and the 64-step divider interpolate. Reset clears the fill count and the origin.
// A result waiting on out_ready holds only the final write, not acceptance.
`default_nettype none
module lsn_time_point_store #(
  parameter int CAPACITY = lts_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic signed [63:0] point_time,
  input  wire logic [63:0]        point_position,
  input  wire logic signed [63:0] now_time,
  input  wire logic [63:0]        now_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             estimate,
  output logic                    dropped,
  output logic [5:0]              drop_slot,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import lts_pkg::*;

  lts_cmd_t    cmd;
  lts_status_t status;

  lts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lts_dp #(.CAP(CAPACITY)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (opcode),
    .point_time     (point_time),
    .point_position (point_position),
    .now_time       (now_time),
    .now_position   (now_position),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .estimate       (estimate),
    .dropped        (dropped),
    .drop_slot      (drop_slot)
  );
endmodule
`default_nettype wire
